[rtl/cht_pkg.sv]
// Package for the chained hash table: request and result types, codes and the key hash.
// Used by cht_bucket_unit and the top level; depends on nothing.
package cht_pkg;

  localparam int LETTER_W   = 5;
  localparam int KEY_LETTERS = 4;
  localparam int KEY_W      = LETTER_W * KEY_LETTERS;
  localparam int HASH_W     = 20;
  localparam int CHAR_W     = 7;
  localparam int LETTER_BASE = 65;
  localparam int HASH_MULT  = 31;
  localparam int STATUS_W   = 3;
  localparam int BUCKET_W   = 4;
  localparam int POSITION_W = 6;
  localparam int MODE_W     = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_POOL_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char0;
    logic [CHAR_W-1:0] char1;
    logic [CHAR_W-1:0] char2;
    logic [CHAR_W-1:0] char3;
  } in_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [BUCKET_W-1:0]   bucket;
    logic [POSITION_W-1:0] position;
  } out_res_t;

  function automatic logic [LETTER_W-1:0] letter_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = c - CHAR_W'(LETTER_BASE);
    return d[LETTER_W-1:0];
  endfunction

  function automatic logic [HASH_W-1:0] key_hash(input logic [KEY_W-1:0] key);
    logic [HASH_W-1:0] v0;
    logic [HASH_W-1:0] v1;
    logic [HASH_W-1:0] v2;
    logic [HASH_W-1:0] v3;
    v0 = HASH_W'(key[4*LETTER_W-1:3*LETTER_W]);
    v1 = HASH_W'(key[3*LETTER_W-1:2*LETTER_W]);
    v2 = HASH_W'(key[2*LETTER_W-1:LETTER_W]);
    v3 = HASH_W'(key[LETTER_W-1:0]);
    return v0 * HASH_W'(HASH_MULT * HASH_MULT * HASH_MULT)
         + v1 * HASH_W'(HASH_MULT * HASH_MULT)
         + v2 * HASH_W'(HASH_MULT) + v3;
  endfunction

endpackage

[rtl/cht_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/cht_bucket_unit.sv]
// Hash of a packed key reduced modulo the bucket count by a reciprocal multiplication.
// The hash, quotient and remainder are registered in turn after the hash load; depends on cht_pkg.
module cht_bucket_unit import cht_pkg::*; #(
  parameter int NUM_BUCKETS = 10
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              load,
  input  logic [KEY_W-1:0]                                  key,
  output logic                                              done,
  output logic [(NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1)-1:0] bucket
);

  localparam int BW          = NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1;
  localparam int RECIP_SHIFT = HASH_W + BW;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = HASH_W + RECIP_W;
  localparam int QN_W        = HASH_W + BW + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));
  localparam logic [BW:0] NB = (BW+1)'(NUM_BUCKETS);

  logic [HASH_W-1:0] h_r;
  logic [HASH_W-1:0] q_r;
  logic [BW-1:0]     rem_r;
  logic [PROD_W-1:0] prod;
  logic [QN_W-1:0]   qn;
  logic [HASH_W-1:0] diff;
  logic              h_vld_r;
  logic              q_vld_r;
  logic              done_r;

  assign prod = PROD_W'(h_r) * PROD_W'(RECIP);
  assign qn   = QN_W'(q_r) * QN_W'(NB);
  assign diff = h_r - qn[HASH_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
      q_vld_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      h_vld_r <= load;
      q_vld_r <= h_vld_r;
      done_r  <= q_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      h_r <= key_hash(key);
    end
    q_r   <= prod[RECIP_SHIFT +: HASH_W];
    rem_r <= diff[BW-1:0];
  end

  assign done   = done_r;
  assign bucket = rem_r;

endmodule

[rtl/chained_hash_table_four_letter_keys.sv]
// Top level of the chained hash table: chain walk controller, entry pool and bucket heads.
// Depends on cht_pkg, cht_ram and cht_bucket_unit.
//
//   channel  ports                    handshake
//   request  in_req                   taken when start is high and busy is low
//   result   out_res                  shown for one cycle while out_valid is high
//
// A clear does not raise busy; its result follows on the next cycle.
// An insert or lookup is busy for hashing and bucket reduction (S_HASH), one head read (S_HCHK),
// then one entry read per chain entry walked (S_ECHK); a miss goes on to S_TAIL.
// An insert that appends to a nonempty chain goes on to S_LINK to link the old tail.
// Reset empties all buckets at once through per-bucket valid bits; the result side
// cannot stall, and a request is taken in the cycle its predecessor's result is shown.
module chained_hash_table_four_letter_keys import cht_pkg::*; #(
  parameter int NUM_BUCKETS = 10,
  parameter int POOL_SIZE   = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_res_t out_res
);

  localparam int BW = NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1;
  localparam int PW = POOL_SIZE > 1 ? $clog2(POOL_SIZE) : 1;
  localparam int LW = $clog2(POOL_SIZE + 1);
  localparam int EW = KEY_W + LW;
  localparam logic [LW-1:0] LINK_EMPTY = LW'(POOL_SIZE);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_HASH = 6'b000010,
    S_HCHK = 6'b000100,
    S_ECHK = 6'b001000,
    S_TAIL = 6'b010000,
    S_LINK = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [MODE_W-1:0]      mode_r, mode_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  logic [KEY_W-1:0]       last_key_r, last_key_nxt;
  logic [LW-1:0]          cur_r, cur_nxt;
  logic [LW-1:0]          pos_r, pos_nxt;
  logic [LW-1:0]          used_r, used_nxt;
  logic                   nonempty_r, nonempty_nxt;
  logic [NUM_BUCKETS-1:0] hvalid_r, hvalid_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_res_t               out_res_r, out_res_nxt;

  logic                   accept;
  logic                   hash_load;
  logic                   hash_done;
  logic [BW-1:0]          bkt;
  logic [LW-1:0]          head_rdata;
  logic [LW-1:0]          head_ptr;
  logic                   head_we;
  logic [EW-1:0]          ent_rdata;
  logic [KEY_W-1:0]       ent_key;
  logic [LW-1:0]          ent_next;
  logic [PW-1:0]          ent_raddr;
  logic                   ent_we;
  logic [PW-1:0]          ent_waddr;
  logic [EW-1:0]          ent_wdata;
  logic [LW+POSITION_W-1:0] pos_ext;
  logic [BW+BUCKET_W-1:0] bkt_ext;
  logic [KEY_W-1:0]       in_key;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign in_key = {letter_value(in_req.char0), letter_value(in_req.char1),
                   letter_value(in_req.char2), letter_value(in_req.char3)};
  assign hash_load = accept && (in_req.mode == MODE_INSERT || in_req.mode == MODE_LOOKUP);

  cht_bucket_unit #(
    .NUM_BUCKETS(NUM_BUCKETS)
  ) u_bucket (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (hash_load),
    .key   (in_key),
    .done  (hash_done),
    .bucket(bkt)
  );

  cht_ram #(
    .WIDTH(LW),
    .DEPTH(NUM_BUCKETS)
  ) u_head_ram (
    .clk  (clk),
    .we   (head_we),
    .waddr(bkt),
    .wdata(used_r),
    .raddr(bkt),
    .rdata(head_rdata)
  );

  cht_ram #(
    .WIDTH(EW),
    .DEPTH(POOL_SIZE)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ent_we),
    .waddr(ent_waddr),
    .wdata(ent_wdata),
    .raddr(ent_raddr),
    .rdata(ent_rdata)
  );

  assign ent_key  = ent_rdata[EW-1:LW];
  assign ent_next = ent_rdata[LW-1:0];
  assign head_ptr = hvalid_r[bkt] ? head_rdata : LINK_EMPTY;
  assign pos_ext  = (LW+POSITION_W)'(pos_r);
  assign bkt_ext  = (BW+BUCKET_W)'(bkt);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    last_key_nxt  = last_key_r;
    cur_nxt       = cur_r;
    pos_nxt       = pos_r;
    used_nxt      = used_r;
    nonempty_nxt  = nonempty_r;
    hvalid_nxt    = hvalid_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    head_we       = 1'b0;
    ent_we        = 1'b0;
    ent_waddr     = used_r[PW-1:0];
    ent_wdata     = {key_r, LINK_EMPTY};
    ent_raddr     = ent_next[PW-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt = in_req.mode;
          key_nxt  = in_key;
          pos_nxt  = '0;
          case (in_req.mode)
            MODE_INSERT, MODE_LOOKUP: begin
              state_nxt = S_HASH;
            end
            MODE_CLEAR: begin
              hvalid_nxt    = '0;
              used_nxt      = '0;
              out_valid_nxt = 1'b1;
              out_res_nxt   = '{status: ST_CLEARED, bucket: '0, position: '0};
            end
            default: begin
            end
          endcase
        end
      end
      S_HASH: begin
        if (hash_done) begin
          state_nxt = S_HCHK;
        end
      end
      S_HCHK: begin
        ent_raddr    = head_ptr[PW-1:0];
        cur_nxt      = head_ptr;
        nonempty_nxt = (head_ptr != LINK_EMPTY);
        state_nxt    = (head_ptr != LINK_EMPTY) ? S_ECHK : S_TAIL;
      end
      S_ECHK: begin
        if (ent_key == key_r) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{status: (mode_r == MODE_INSERT) ? ST_PRESENT : ST_FOUND,
                            bucket: bkt_ext[BUCKET_W-1:0],
                            position: pos_ext[POSITION_W-1:0]};
          state_nxt     = S_IDLE;
        end else begin
          pos_nxt      = pos_r + LW'(1);
          last_key_nxt = ent_key;
          if (ent_next == LINK_EMPTY) begin
            state_nxt = S_TAIL;
          end else begin
            cur_nxt = ent_next;
          end
        end
      end
      S_TAIL: begin
        out_res_nxt.bucket = bkt_ext[BUCKET_W-1:0];
        if (mode_r == MODE_LOOKUP) begin
          out_valid_nxt        = 1'b1;
          out_res_nxt.status   = ST_NOT_FOUND;
          out_res_nxt.position = '0;
          state_nxt            = S_IDLE;
        end else if (used_r == LW'(POOL_SIZE)) begin
          out_valid_nxt        = 1'b1;
          out_res_nxt.status   = ST_POOL_FULL;
          out_res_nxt.position = '0;
          state_nxt            = S_IDLE;
        end else begin
          ent_we = 1'b1;
          if (nonempty_r) begin
            state_nxt = S_LINK;
          end else begin
            head_we              = 1'b1;
            hvalid_nxt[bkt]      = 1'b1;
            used_nxt             = used_r + LW'(1);
            out_valid_nxt        = 1'b1;
            out_res_nxt.status   = ST_INSERTED;
            out_res_nxt.position = pos_ext[POSITION_W-1:0];
            state_nxt            = S_IDLE;
          end
        end
      end
      S_LINK: begin
        ent_we               = 1'b1;
        ent_waddr            = cur_r[PW-1:0];
        ent_wdata            = {last_key_r, used_r};
        used_nxt             = used_r + LW'(1);
        out_valid_nxt        = 1'b1;
        out_res_nxt.status   = ST_INSERTED;
        out_res_nxt.bucket   = bkt_ext[BUCKET_W-1:0];
        out_res_nxt.position = pos_ext[POSITION_W-1:0];
        state_nxt            = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      hvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      hvalid_r    <= hvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    key_r      <= key_nxt;
    last_key_r <= last_key_nxt;
    cur_r      <= cur_nxt;
    pos_r      <= pos_nxt;
    nonempty_r <= nonempty_nxt;
    out_res_r  <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef ASSERT_OFF
  a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy fell without a result strobe");

  a_head_valid_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    ((hvalid_r & ~$past(hvalid_r)) != '0) |-> $past(head_we))
    else $error("bucket head became valid without a head write");

  a_pool_grows_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != $past(used_r) && used_r != '0) |-> (out_valid && out_res.status == ST_INSERTED))
    else $error("entry pool grew without an inserted result");

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ent_we |-> (state_r == S_LINK || used_r < LW'(POOL_SIZE)))
    else $error("new entry written past the end of the pool");
`endif

endmodule
